>>> hw/rtl/kfd_pkg.sv
// shared types and constants for the kiss frame decoder
package kfd_pkg;

	localparam logic [7:0] FEND  = 8'hC0;
	localparam logic [7:0] FESC  = 8'hDB;
	localparam logic [7:0] TFEND = 8'hDC;
	localparam logic [7:0] TFESC = 8'hDD;
	localparam logic [7:0] CMD_DATA = 8'h00;

	localparam logic [9:0] CAP_RESET = 10'd512;

	localparam int Q_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_SKIP  = 2'd0,
		PH_DATA  = 2'd1,
		PH_OTHER = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OTHER = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	// one entry of work for the back end: an optional data byte and an optional status
	typedef struct packed {
		logic       has_data;
		logic [7:0] data;
		logic       has_status;
		status_t    status;
		logic [7:0] command;
		logic [9:0] length;
	} op_t;

endpackage

>>> hw/rtl/kiss_frame_decoder_unit.sv
// kiss frame decoder top level: front end, work queue and output back end
// throughput: one input byte per cycle while the queue has room; a byte that ends
//   a frame and also yields a data byte gives two output items (data, then status)
// path: a byte's result is written into the work queue, then loaded into the output register
// the four-entry queue keeps the input side running while a result waits on m_tready
// reset: arst_n clears frame state and queue, out_capacity returns to 512
module kiss_frame_decoder_unit #(
	parameter int MAX_FRAME = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,   // out_capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] in_byte
	input  logic        s_tlast,     // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [7:0] out_byte, [9:8] status, [17:10] command,
	                                 // [27:18] length, rest zero
	output logic        m_tlast      // is_status
);
	import kfd_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	op_t  q_op;
	op_t  q_head;

	kfd_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (q_op)
	);

	kfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_op),
		.pop     (q_pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (q_head)
	);

	kfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> hw/rtl/kfd_front.sv
// front end: takes raw bytes, tracks frame state, queues data and status work
module kfd_front #(
	parameter int MAX_FRAME = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [9:0]    cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          s_tlast,
	input  logic          q_full,
	output logic          q_push,
	output kfd_pkg::op_t  q_op
);
	import kfd_pkg::*;

	localparam int BW = $clog2(MAX_FRAME + 2);
	localparam logic [BW-1:0] MAX_B = BW'(MAX_FRAME);

	phase_t        phase_q, phase_d;
	logic [7:0]    cmd_q, cmd_d;
	logic          esc_q, esc_d;
	logic          delim_q, delim_d;
	logic          err_q, err_d;
	logic [BW-1:0] bc_q, bc_d;
	logic [9:0]    oc_q, oc_d;
	logic [9:0]    cap_q;
	logic          want;
	logic [7:0]    want_byte;
	logic          accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			cmd_q   <= '0;
			esc_q   <= 1'b0;
			delim_q <= 1'b0;
			err_q   <= 1'b0;
			bc_q    <= '0;
			oc_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			esc_q   <= esc_d;
			delim_q <= delim_d;
			err_q   <= err_d;
			bc_q    <= bc_d;
			oc_q    <= oc_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		esc_d     = esc_q;
		delim_d   = delim_q;
		err_d     = err_q;
		bc_d      = bc_q;
		oc_d      = oc_q;
		want      = 1'b0;
		want_byte = s_tdata;
		q_op      = '0;

		unique case (phase_q)
			PH_SKIP: begin
				if (s_tdata != FEND) begin
					cmd_d   = s_tdata;
					phase_d = (s_tdata == CMD_DATA) ? PH_DATA : PH_OTHER;
				end
			end
			PH_DATA: begin
				if (!err_q) begin
					if (s_tdata == FEND) begin
						delim_d = 1'b1;
					end else if (delim_q) begin
						err_d = 1'b1;
					end else begin
						// body count saturates one past the limit
						if (bc_q <= MAX_B) begin
							bc_d = bc_q + 1'b1;
						end
						if (bc_q >= MAX_B) begin
							err_d = 1'b1;
						end else if (esc_q) begin
							esc_d = 1'b0;
							if (s_tdata == TFEND) begin
								want      = 1'b1;
								want_byte = FEND;
							end else if (s_tdata == TFESC) begin
								want      = 1'b1;
								want_byte = FESC;
							end else begin
								err_d = 1'b1;
							end
						end else if (s_tdata == FESC) begin
							esc_d = 1'b1;
						end else begin
							want = 1'b1;
						end
					end
				end
			end
			PH_OTHER: begin
			end
			default: begin
			end
		endcase

		// receiving buffer full: drop the byte and mark the frame
		if (want) begin
			if (oc_q >= cap_q) begin
				err_d = 1'b1;
			end else begin
				oc_d          = oc_q + 1'b1;
				q_op.has_data = 1'b1;
				q_op.data     = want_byte;
			end
		end

		if (s_tlast) begin
			q_op.has_status = 1'b1;
			q_op.command    = cmd_d;
			if (phase_d == PH_SKIP) begin
				q_op.status = ST_BAD;
			end else if (phase_d == PH_OTHER) begin
				q_op.status = ST_OTHER;
			end else if (err_d || esc_d) begin
				q_op.status = ST_BAD;
			end else begin
				q_op.status = ST_OK;
				q_op.length = oc_d;
			end
			phase_d = PH_SKIP;
			cmd_d   = '0;
			esc_d   = 1'b0;
			delim_d = 1'b0;
			err_d   = 1'b0;
			bc_d    = '0;
			oc_d    = '0;
		end

		q_push = accept && (q_op.has_data || q_op.has_status);
	end

endmodule

>>> hw/rtl/kfd_queue.sv
// short fifo of work entries between front and back end
module kfd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kfd_pkg::op_t  push_op,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output kfd_pkg::op_t  head
);
	import kfd_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	op_t         mem_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (PW+1)'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/kfd_back.sv
// back end: drains work entries into the output register, data before status
module kfd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  kfd_pkg::op_t  q_head,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic          m_tlast
);
	import kfd_pkg::*;

	logic        valid_q;
	logic [31:0] data_q;
	logic        last_q;
	logic        data_done_q;
	logic        load;
	logic        send_data;

	assign load      = (!valid_q || m_tready) && !q_empty;
	// the data half of an entry goes out first, the status half on the next request
	assign send_data = q_head.has_data && !data_done_q;
	assign q_pop     = load && !(send_data && q_head.has_status);

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			data_done_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q     <= 1'b1;
				data_done_q <= send_data && q_head.has_status;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_data) begin
				data_q <= {24'd0, q_head.data};
				last_q <= 1'b0;
			end else begin
				data_q <= {4'd0, q_head.length, q_head.command, q_head.status, 8'd0};
				last_q <= 1'b1;
			end
		end
	end

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the kiss frame decoder unit
`timescale 1ns / 100ps

module tb;

	import kfd_pkg::*;

	localparam int MAX_FRAME   = 512;
	localparam int PHASE_ITEMS = 50;
	localparam int RX_HOLD     = 200;
	localparam int N_PHASES    = 7;
	localparam int N_DIRECTED  = 26;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		status_t    status;
		logic [7:0] command;
		logic [9:0] length;
	} kiss_item_t;

	// one stimulus row; known rows carry the status item typed in by hand
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       known;
		status_t    st;
		logic [7:0] cmd;
		logic [9:0] len;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [9:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	// frame decoding state mirrored from the block
	phase_t     fr_phase = PH_SKIP;
	logic [7:0] fr_cmd   = 8'h00;
	logic       fr_esc   = 1'b0;
	logic       fr_delim = 1'b0;
	logic       fr_err   = 1'b0;
	int         fr_body  = 0;
	int         fr_out   = 0;
	logic [9:0] cap_now  = CAP_RESET;

	kiss_item_t step_items[$];
	kiss_item_t decoded_q[$];
	logic [7:0] frame_q[$];

	int   mismatches = 0;
	logic tx_eager   = 1'b0;
	logic rx_eager   = 1'b0;
	logic hold_req   = 1'b0;

	row_t dir_rows [N_DIRECTED] = '{
		// delimiters only
		'{8'hC0, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hC0, 1'b1, 1'b1, ST_BAD,   8'h00, 10'd0},
		// bare data command, empty body
		'{8'h00, 1'b1, 1'b1, ST_OK,    8'h00, 10'd0},
		// both escapes, trailing delimiter
		'{8'h00, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hDB, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hDC, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hDB, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hDD, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hC0, 1'b1, 1'b0, ST_OK,    8'h00, 10'd0},
		// interior delimiter
		'{8'h00, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'h55, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hC0, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'h66, 1'b1, 1'b0, ST_OK,    8'h00, 10'd0},
		// unknown escape
		'{8'h00, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hDB, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'h41, 1'b1, 1'b0, ST_OK,    8'h00, 10'd0},
		// escape left dangling at the end
		'{8'h00, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'h12, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hDB, 1'b1, 1'b0, ST_OK,    8'h00, 10'd0},
		// non-data commands, body not checked
		'{8'hFF, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hDB, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'h77, 1'b1, 1'b1, ST_OTHER, 8'hFF, 10'd0},
		'{8'h80, 1'b1, 1'b1, ST_OTHER, 8'h80, 10'd0},
		// data byte and status on the same request
		'{8'h00, 1'b0, 1'b0, ST_OK,    8'h00, 10'd0},
		'{8'hAA, 1'b1, 1'b0, ST_OK,    8'h00, 10'd0}
	};

	kiss_frame_decoder_unit #(
		.MAX_FRAME(MAX_FRAME)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input int got_v, input int exp_v);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s got %0h expected %0h", $time, what, got_v, exp_v);
	endtask

	function automatic void put_byte(input logic [7:0] d);
		if (fr_out >= int'(cap_now)) begin
			fr_err = 1'b1;
		end else begin
			fr_out++;
			step_items.push_back('{d, 1'b0, ST_OK, 8'h00, 10'd0});
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		status_t    st;
		logic [9:0] len;
		step_items.delete();
		if (fr_phase == PH_SKIP) begin
			if (b != FEND) begin
				fr_cmd = b;
				fr_phase = (b == CMD_DATA) ? PH_DATA : PH_OTHER;
			end
		end else if (fr_phase == PH_DATA && !fr_err) begin
			if (b == FEND) begin
				fr_delim = 1'b1;
			end else if (fr_delim) begin
				fr_err = 1'b1;
			end else begin
				// body count saturates one past the maximum
				if (fr_body <= MAX_FRAME)
					fr_body++;
				if (fr_body > MAX_FRAME) begin
					fr_err = 1'b1;
				end else if (fr_esc) begin
					fr_esc = 1'b0;
					if (b == TFEND)
						put_byte(FEND);
					else if (b == TFESC)
						put_byte(FESC);
					else
						fr_err = 1'b1;
				end else if (b == FESC) begin
					fr_esc = 1'b1;
				end else begin
					put_byte(b);
				end
			end
		end
		if (last) begin
			len = '0;
			if (fr_phase == PH_SKIP)
				st = ST_BAD;
			else if (fr_phase == PH_OTHER)
				st = ST_OTHER;
			else if (fr_err || fr_esc)
				st = ST_BAD;
			else begin
				st = ST_OK;
				len = 10'(fr_out);
			end
			step_items.push_back('{8'h00, 1'b1, st, fr_cmd, len});
			fr_phase = PH_SKIP;
			fr_cmd = 8'h00;
			fr_esc = 1'b0;
			fr_delim = 1'b0;
			fr_err = 1'b0;
			fr_body = 0;
			fr_out = 0;
		end
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0: return FEND;
			1: return FESC;
			2: return TFEND;
			3: return TFESC;
			4: return 8'h00;
			5: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void push_escaped(input logic [7:0] d);
		if (d == FEND) begin
			frame_q.push_back(FESC);
			frame_q.push_back(TFEND);
		end else if (d == FESC) begin
			frame_q.push_back(FESC);
			frame_q.push_back(TFESC);
		end else begin
			frame_q.push_back(d);
		end
	endfunction

	// starts and ends at a falling edge with the request dropped
	task automatic send_row(input row_t r);
		int gap;
		int k;
		gap = 0;
		if (!tx_eager) begin
			k = $urandom_range(0, 99);
			if (k >= 92)
				gap = $urandom_range(8, 30);
			else if (k >= 60)
				gap = $urandom_range(1, 3);
		end
		repeat (gap) @(negedge clk);
		s_tdata = r.b;
		s_tlast = r.last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		decode_byte(r.b, r.last);
		if (r.known)
			decoded_q.push_back('{8'h00, 1'b1, r.st, r.cmd, r.len});
		else
			foreach (step_items[j])
				decoded_q.push_back(step_items[j]);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_frame();
		row_t r;
		for (int i = 0; i < frame_q.size(); i++) begin
			r = '0;
			r.b = frame_q[i];
			r.last = (i == frame_q.size() - 1);
			send_row(r);
		end
	endtask

	// frames with no result may still be in flight when the queue empties
	task automatic wait_drained();
		while (decoded_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		kiss_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("result with none expected", m_tdata, 0);
			end else begin
				want = decoded_q.pop_front();
				if (m_tdata[7:0] !== want.out_byte)
					report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
				if (m_tlast !== want.is_status)
					report_mismatch("is_status", m_tlast, want.is_status);
				if (m_tdata[9:8] !== want.status)
					report_mismatch("status", m_tdata[9:8], want.status);
				if (m_tdata[17:10] !== want.command)
					report_mismatch("command", m_tdata[17:10], want.command);
				if (m_tdata[27:18] !== want.length)
					report_mismatch("length", m_tdata[27:18], want.length);
			end
		end
	end

	initial begin : rx_side
		int stall;
		int r;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = RX_HOLD;
			end
			if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else if (rx_eager) begin
				m_tready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready = 1'b1;
				end else begin
					m_tready = 1'b0;
					stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end
			end
		end
	end

	initial begin : stimulus
		logic [9:0] caps [N_PHASES];
		int         sent;
		int         kind;
		int         n;
		int         pos;
		logic [7:0] d;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows run at the reset capacity
		foreach (dir_rows[i])
			send_row(dir_rows[i]);
		wait_drained();

		caps[0] = 10'd0;
		caps[1] = CAP_RESET;
		caps[2] = 10'd1;
		caps[3] = 10'd3;
		caps[4] = 10'($urandom_range(2, 20));
		caps[5] = 10'($urandom_range(0, 512));
		caps[6] = CAP_RESET;

		for (int p = 0; p < N_PHASES; p++) begin
			cfg_wdata = caps[p];
			cfg_we = 1'b1;
			@(negedge clk);
			cfg_we = 1'b0;
			cap_now = caps[p];
			tx_eager = (p == 2) || ($urandom_range(0, 4) == 0);
			rx_eager = (p == 2) || ($urandom_range(0, 4) == 0);

			if (p == 1) begin
				// receiver holds off while the longest frames start to stream in
				hold_req = 1'b1;
				frame_q.delete();
				frame_q.push_back(CMD_DATA);
				repeat (MAX_FRAME) begin
					d = 8'($urandom);
					if (d == FEND || d == FESC)
						d = 8'h5A;
					frame_q.push_back(d);
				end
				send_frame();
				frame_q.delete();
				frame_q.push_back(CMD_DATA);
				n = MAX_FRAME + 2 + $urandom_range(0, 3);
				while (frame_q.size() < n)
					push_escaped(pick_byte());
				send_frame();
			end

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				frame_q.delete();
				kind = $urandom_range(0, 99);
				if (kind >= 93) begin
					repeat ($urandom_range(1, 3)) frame_q.push_back(FEND);
				end else if (kind >= 85) begin
					repeat ($urandom_range(1, 10)) frame_q.push_back(pick_byte());
				end else begin
					repeat ($urandom_range(0, 2)) frame_q.push_back(FEND);
					if (kind >= 55 && kind < 70) begin
						do d = 8'($urandom_range(1, 255)); while (d == FEND);
						frame_q.push_back(d);
						repeat ($urandom_range(0, 10)) frame_q.push_back(pick_byte());
					end else begin
						frame_q.push_back(CMD_DATA);
						n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
							: $urandom_range(0, 12);
						repeat (n) push_escaped(pick_byte());
						repeat ($urandom_range(0, 2)) frame_q.push_back(FEND);
						// broken frame: dangling escape or one corrupted byte
						if (kind >= 70) begin
							if ($urandom_range(0, 3) == 0) begin
								frame_q.push_back(FESC);
							end else begin
								pos = $urandom_range(0, frame_q.size() - 1);
								case ($urandom_range(0, 2))
									0: frame_q[pos] = FEND;
									1: frame_q[pos] = FESC;
									default: frame_q[pos] = 8'($urandom);
								endcase
							end
						end
					end
				end
				sent += frame_q.size();
				send_frame();
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("** kiss_frame_decoder_unit: PASSED **");
		else
			$display("** kiss_frame_decoder_unit: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("** kiss_frame_decoder_unit: FAILED **");
		$finish;
	end

endmodule
